// ===== rtl/nearest_anchor_angle_search_macros.svh =====
// Assertion macros for the nearest anchor angle search block.
`ifndef NEAREST_ANCHOR_ANGLE_SEARCH_MACROS_SVH
`define NEAREST_ANCHOR_ANGLE_SEARCH_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define NAAS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("naas assertion failed");
// Next-cycle implication.
`define NAAS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("naas assertion failed");
`else
`define NAAS_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define NAAS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/naas_pkg.sv =====
// Shared constants, types and the anchor ROM contents for the angle search.
package naas_pkg;

   localparam int QUADRANT_ANCHORS = 64;
   localparam int FRACTION_BITS    = 12;
   localparam int FULL_ANCHORS     = 4 * QUADRANT_ANCHORS;
   localparam int QA_W             = $clog2(QUADRANT_ANCHORS);
   localparam int IDX_W            = $clog2(FULL_ANCHORS);
   localparam int IN_W             = 16;
   localparam int OUT_W            = 8;
   localparam int TRIG_W           = FRACTION_BITS + 1;
   localparam int ENTRY_W          = 2 * TRIG_W;
   localparam int D_W = ((FRACTION_BITS + 2 > IN_W) ? FRACTION_BITS + 2 : IN_W) + 1;
   localparam int SQ_W             = 2 * D_W;
   localparam int ERR_W            = SQ_W + 1;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FULL_ANCHORS - 1);
   localparam logic [QA_W-1:0]  LAST_T   = QA_W'(QUADRANT_ANCHORS - 1);
   localparam logic signed [D_W-1:0] ONE_FIX = D_W'(1) << FRACTION_BITS;

   localparam logic OP_ATAN2 = 1'b0;
   localparam logic OP_ASIN  = 1'b1;

   localparam logic [1:0] QUAD_I   = 2'd0;
   localparam logic [1:0] QUAD_II  = 2'd1;
   localparam logic [1:0] QUAD_III = 2'd2;
   localparam logic [1:0] QUAD_IV  = 2'd3;

   // Series arithmetic for building the ROM, 60 fraction bits.
   localparam int          HP_BITS         = 60;
   localparam logic [63:0] HP_QUARTER_TURN = 64'h1921FB54442D1847;
   localparam int          SERIES_TERMS    = 30;
   localparam logic [63:0] Q_STEP = HP_QUARTER_TURN / 64'(QUADRANT_ANCHORS);
   localparam logic [63:0] R_STEP = HP_QUARTER_TURN % 64'(QUADRANT_ANCHORS);

   typedef logic [QUADRANT_ANCHORS-1:0][ENTRY_W-1:0] rom_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic [ERR_W-1:0] err;
   } cand_type;

   function automatic logic [63:0] hp_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[HP_BITS+63:HP_BITS];
   endfunction

   // Restoring long division by a small divisor.
   function automatic logic [63:0] div_small(input logic [63:0] num, input logic [15:0] den);
      logic [63:0] quo;
      logic [16:0] rem;
      quo = '0;
      rem = '0;
      for (int k = 63; k >= 0; k--) begin
         rem = {rem[15:0], num[k]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[k] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Taylor series: odd clear gives cos, odd set gives sin.
   function automatic logic signed [63:0] hp_series(input logic [63:0] x, input logic odd);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        den;
      logic signed [63:0] sum;
      x2   = hp_mul(x, x);
      term = odd ? x : (64'd1 << HP_BITS);
      sum  = $signed(term);
      for (int k = 1; k < SERIES_TERMS; k++) begin
         den  = odd ? 64'((2 * k) * (2 * k + 1)) : 64'((2 * k - 1) * (2 * k));
         term = div_small(hp_mul(term, x2), den[15:0]);
         if (k[0]) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      return sum;
   endfunction

   function automatic logic [TRIG_W-1:0] hp_round(input logic signed [63:0] v);
      logic [63:0] u;
      u = (v < 0) ? 64'd0 : $unsigned(v);
      u = u + (64'd1 << (HP_BITS - FRACTION_BITS - 1));
      u = u >> (HP_BITS - FRACTION_BITS);
      return u[TRIG_W-1:0];
   endfunction

   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] theta;
      for (int i = 0; i < QUADRANT_ANCHORS; i++) begin
         theta  = Q_STEP * 64'(i) + (R_STEP * 64'(i)) / QUADRANT_ANCHORS;
         rom[i] = {hp_round(hp_series(theta, 1'b0)), hp_round(hp_series(theta, 1'b1))};
      end
      return rom;
   endfunction

   // Entry i: {cos, sin} of i steps of a quarter turn / QUADRANT_ANCHORS, unsigned, FRACTION_BITS fraction bits.
   localparam rom_type QUAD_ROM = build_rom();

endpackage

// ===== rtl/naas_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module naas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/naas_err.sv =====
// Distance pipeline: unfolds a ROM entry by quadrant and forms the squared error.
module naas_err
   import naas_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  issue_valid,
   input  logic [IDX_W-1:0]      issue_idx,
   input  logic [1:0]            issue_quad,
   input  logic [ENTRY_W-1:0]    rd_data,
   input  logic                  op,
   input  logic signed [D_W-1:0] x_fix,
   input  logic signed [D_W-1:0] y_fix,
   output cand_type              cand
);

   // stage 0: tag aligned with RAM read data
   logic             v0_ff;
   logic [IDX_W-1:0] idx0_ff;
   logic [1:0]       q0_ff;
   // stage 1: differences
   logic                  v1_ff;
   logic [IDX_W-1:0]      idx1_ff;
   logic signed [D_W-1:0] dx1_ff, dx1_in;
   logic signed [D_W-1:0] dy1_ff, dy1_in;
   // stage 2: squares
   logic                   v2_ff;
   logic [IDX_W-1:0]       idx2_ff;
   logic signed [SQ_W-1:0] sqx2_ff, sqx2_in;
   logic signed [SQ_W-1:0] sqy2_ff, sqy2_in;

   logic signed [D_W-1:0] cos_q, sin_q, c_anc, s_anc;

   always_comb begin
      cos_q = $signed(D_W'(rd_data[ENTRY_W-1:TRIG_W]));
      sin_q = $signed(D_W'(rd_data[TRIG_W-1:0]));
      unique case (q0_ff)
         QUAD_I: begin
            c_anc = cos_q;
            s_anc = sin_q;
         end
         QUAD_II: begin
            c_anc = -sin_q;
            s_anc = cos_q;
         end
         QUAD_III: begin
            c_anc = -cos_q;
            s_anc = -sin_q;
         end
         default: begin
            c_anc = sin_q;
            s_anc = -cos_q;
         end
      endcase
      dx1_in  = c_anc - x_fix;
      dy1_in  = s_anc - y_fix;
      sqx2_in = dx1_ff * dx1_ff;
      sqy2_in = dy1_ff * dy1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= issue_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
      idx0_ff <= issue_idx;
      q0_ff   <= issue_quad;
      idx1_ff <= idx0_ff;
      dx1_ff  <= dx1_in;
      dy1_ff  <= dy1_in;
      idx2_ff <= idx1_ff;
      sqx2_ff <= sqx2_in;
      sqy2_ff <= sqy2_in;
   end

   always_comb begin
      cand.valid = v2_ff;
      cand.idx   = idx2_ff;
      cand.err   = ERR_W'($unsigned(sqy2_ff))
                 + ((op == OP_ATAN2) ? ERR_W'($unsigned(sqx2_ff)) : ERR_W'(0));
   end

endmodule

// ===== rtl/nearest_anchor_angle_search.sv =====
// Top level of the nearest anchor angle search: control, anchor memory and best tracking.
//
// Returns, for each transfer in, the index of the nearest of FULL_ANCHORS (256) anchors
// evenly spaced on the unit circle, so the angle is index * tau / 256. Opcode atan2
// measures squared distance from (x, y) to (cos, sin); opcode asin clamps y to [-1, 1]
// and compares only the sine. Values are signed Q3.12; ties go to the lowest index, and
// atan2 of the origin returns 0 at once. The quadrant cos/sin table lives in a 64-entry
// RAM that is loaded from a constant table after reset; req_ready stays low until that
// load finishes. The search streams one anchor per cycle out of the RAM's single read
// port through a three-stage distance pipeline, while the origin case skips the scan and
// goes straight to ST_DONE. req_ready comes back together with rsp_valid. One item is in
// flight at a time; the next can be accepted while the previous result still waits in
// the output register, and a finished search holds in ST_DONE for as long as that
// earlier result is stalled by rsp_ready.
module nearest_anchor_angle_search
   import naas_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_opcode,
   input  logic signed [IN_W-1:0] req_x_value,
   input  logic signed [IN_W-1:0] req_y_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OUT_W-1:0]       rsp_angle_index
);

`include "nearest_anchor_angle_search_macros.svh"

   localparam logic [2:0] ST_INIT  = 3'd0;  // loading the anchor RAM
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;  // issuing one anchor read per cycle
   localparam logic [2:0] ST_DRAIN = 3'd3;  // waiting for the last anchor to leave the pipe
   localparam logic [2:0] ST_DONE  = 3'd4;  // result waits for the output register

   logic [2:0]            state_ff, state_in;
   logic [QA_W-1:0]       init_cnt_ff, init_cnt_in;
   logic [QA_W-1:0]       t_ff, t_in;        // entry within quadrant
   logic [1:0]            q_ff, q_in;        // quadrant
   logic [IDX_W-1:0]      j_ff, j_in;        // full-circle anchor index
   logic                  op_ff, op_in;
   logic signed [D_W-1:0] x_ff, x_in;
   logic signed [D_W-1:0] y_ff, y_in;
   logic [IDX_W-1:0]      best_ff, best_in;
   logic [ERR_W-1:0]      best_err_ff, best_err_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]      rsp_idx_ff, rsp_idx_in;

   logic                  accept;
   logic                  is_origin;
   logic signed [D_W-1:0] y_ext;
   logic [ENTRY_W-1:0]    rd_data;
   cand_type              cand;

   assign req_ready       = (state_ff == ST_IDLE);
   assign accept          = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_angle_index = rsp_idx_ff;

   assign is_origin = (req_opcode == OP_ATAN2) && (req_x_value == '0) && (req_y_value == '0);
   assign y_ext     = D_W'(req_y_value);

   naas_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUADRANT_ANCHORS)
   ) u_anchor_ram (
      .clock   (clock),
      .wr_en   (state_ff == ST_INIT),
      .wr_addr (init_cnt_ff),
      .wr_data (QUAD_ROM[init_cnt_ff]),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (t_ff),
      .rd_data (rd_data)
   );

   naas_err u_err (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (state_ff == ST_SCAN),
      .issue_idx   (j_ff),
      .issue_quad  (q_ff),
      .rd_data     (rd_data),
      .op          (op_ff),
      .x_fix       (x_ff),
      .y_fix       (y_ff),
      .cand        (cand)
   );

   always_comb begin
      state_in     = state_ff;
      init_cnt_in  = init_cnt_ff;
      t_in         = t_ff;
      q_in         = q_ff;
      j_in         = j_ff;
      op_in        = op_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      best_in      = best_ff;
      best_err_in  = best_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_idx_in   = rsp_idx_ff;

      // running minimum; strict compare keeps the lowest index on ties
      if (cand.valid && ((cand.idx == '0) || (cand.err < best_err_ff))) begin
         best_in     = cand.idx;
         best_err_in = cand.err;
      end

      unique case (state_ff)
         ST_INIT: begin
            init_cnt_in = init_cnt_ff + QA_W'(1);
            if (init_cnt_ff == LAST_T) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in = req_opcode;
               x_in  = D_W'(req_x_value);
               y_in  = y_ext;
               if (req_opcode == OP_ASIN) begin
                  if (y_ext > ONE_FIX) begin
                     y_in = ONE_FIX;
                  end else if (y_ext < -ONE_FIX) begin
                     y_in = -ONE_FIX;
                  end
               end
               t_in = '0;
               q_in = QUAD_I;
               j_in = '0;
               if (is_origin) begin
                  best_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            j_in = j_ff + IDX_W'(1);
            if (t_ff == LAST_T) begin
               t_in = '0;
               q_in = q_ff + 2'd1;
            end else begin
               t_in = t_ff + QA_W'(1);
            end
            if (j_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (cand.valid && (cand.idx == LAST_IDX)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = OUT_W'(best_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t_ff        <= t_in;
      q_ff        <= q_in;
      j_ff        <= j_in;
      op_ff       <= op_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      best_ff     <= best_in;
      best_err_ff <= best_err_in;
      rsp_idx_ff  <= rsp_idx_in;
   end

   // An accepted transfer always starts a scan or takes the origin shortcut.
   `NAAS_ASSERT_NEXT(a_accept_starts, clock, reset, accept,
      (state_ff == ST_SCAN) || (state_ff == ST_DONE))
   // Distance results only come back while a search is running.
   `NAAS_ASSERT_NOW(a_cand_in_search, clock, reset, cand.valid,
      (state_ff == ST_SCAN) || (state_ff == ST_DRAIN))
   // The asin argument never leaves [-1, 1] once clamped.
   `NAAS_ASSERT_NOW(a_asin_clamped, clock, reset,
      (op_ff == OP_ASIN) && ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN)),
      (y_ff <= ONE_FIX) && (y_ff >= -ONE_FIX))

endmodule

// ===== tb/tb.sv =====
// Testbench for the nearest anchor angle search block: stimulus, index prediction, checking.
`timescale 1ns / 100ps

module tb
   import naas_pkg::*;
();

   // Run limits. Most items spend a full anchor scan in the block, and each can also see an
   // idle burst from the sender and a stall burst from the receiver. The limit allows for
   // about 2000 items several times over.
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int TAIL_CYCLES  = 300;

   // Fixed-point series arithmetic used to rebuild the anchor table, 60 fraction bits.
   localparam int          SERIES_FRAC  = 60;
   localparam logic [63:0] QUARTER_TURN = 64'h1921FB54442D1847;
   localparam int          SERIES_LEN   = 30;
   localparam longint      UNIT         = longint'(1) << FRACTION_BITS;

   // DUT inputs start at known values, outputs are plain wires.
   logic                   clock           = 1'b0;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_opcode      = OP_ATAN2;
   logic signed [IN_W-1:0] req_x_value     = '0;
   logic signed [IN_W-1:0] req_y_value     = '0;
   logic                   rsp_ready       = 1'b0;
   wire                    req_ready;
   wire                    rsp_valid;
   wire [OUT_W-1:0]        rsp_angle_index;

   // Predicted indexes wait here, oldest first, until their transfer comes out.
   logic [OUT_W-1:0] angle_expected[$];
   logic [OUT_W-1:0] angle_want;

   // Quadrant cos/sin table, rebuilt at time zero.
   longint anchor_cos[QUADRANT_ANCHORS];
   longint anchor_sin[QUADRANT_ANCHORS];

   int  error_count     = 0;
   int  items_sent      = 0;
   int  results_checked = 0;
   int  cycle_count     = 0;
   bit  sender_gaps     = 1'b1;   // random idle bursts on the request side
   bit  receiver_stalls = 1'b1;   // random backpressure bursts on the response side

   nearest_anchor_angle_search uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_x_value     (req_x_value),
      .req_y_value     (req_y_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_angle_index (rsp_angle_index)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Index prediction
   // ---------------------------------------------------------------------------------

   // (a * b) >> 60 on unsigned operands.
   function automatic logic [63:0] frac60_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] full;
      full = 128'(a) * 128'(b);
      return 64'(full >> SERIES_FRAC);
   endfunction

   // Power series for cos (want_sin clear) or sin (want_sin set), theta in [0, tau/4].
   function automatic longint series_trig(input logic [63:0] theta, input bit want_sin);
      logic [63:0] theta_sq;
      logic [63:0] term;
      logic [63:0] divisor;
      longint      acc;
      theta_sq = frac60_mul(theta, theta);
      term     = want_sin ? theta : (64'd1 << SERIES_FRAC);
      acc      = longint'(term);
      for (int k = 1; k < SERIES_LEN; k++) begin
         divisor = want_sin ? 64'((2 * k) * (2 * k + 1)) : 64'((2 * k - 1) * (2 * k));
         term    = frac60_mul(term, theta_sq) / divisor;
         if (k % 2 == 1) begin
            acc -= longint'(term);
         end else begin
            acc += longint'(term);
         end
      end
      return acc;
   endfunction

   // Round to nearest at FRACTION_BITS; negatives (tiny series error) go to zero.
   function automatic longint round_to_fix(input longint v);
      logic [63:0] mag;
      mag = (v < 0) ? 64'd0 : 64'(v);
      mag = mag + (64'd1 << (SERIES_FRAC - FRACTION_BITS - 1));
      return longint'(mag >> (SERIES_FRAC - FRACTION_BITS));
   endfunction

   function automatic void load_anchor_table();
      logic [63:0] step_whole;
      logic [63:0] step_rem;
      logic [63:0] theta;
      step_whole = QUARTER_TURN / 64'(QUADRANT_ANCHORS);
      step_rem   = QUARTER_TURN % 64'(QUADRANT_ANCHORS);
      for (int i = 0; i < QUADRANT_ANCHORS; i++) begin
         theta         = step_whole * 64'(i) + (step_rem * 64'(i)) / 64'(QUADRANT_ANCHORS);
         anchor_cos[i] = round_to_fix(series_trig(theta, 1'b0));
         anchor_sin[i] = round_to_fix(series_trig(theta, 1'b1));
      end
   endfunction

   // Full-circle anchor j, unfolded from the quadrant table by symmetry.
   function automatic void anchor_of(input int j, output longint c, output longint s);
      logic [1:0] quad;
      int         t;
      quad = 2'(j / QUADRANT_ANCHORS);
      t    = j % QUADRANT_ANCHORS;
      unique case (quad)
         QUAD_I:   begin c =  anchor_cos[t]; s =  anchor_sin[t]; end
         QUAD_II:  begin c = -anchor_sin[t]; s =  anchor_cos[t]; end
         QUAD_III: begin c = -anchor_cos[t]; s = -anchor_sin[t]; end
         QUAD_IV:  begin c =  anchor_sin[t]; s = -anchor_cos[t]; end
      endcase
   endfunction

   // Exhaustive nearest-anchor search; strict compare keeps the lowest index on ties.
   function automatic logic [OUT_W-1:0] nearest_anchor(input logic op,
                                                       input logic signed [IN_W-1:0] x,
                                                       input logic signed [IN_W-1:0] y);
      longint px, py, ac, as_val, dx, dy, sq_err, best_err;
      int     best;
      px = x;
      py = y;
      if (op == OP_ATAN2 && px == 0 && py == 0) begin
         return '0;
      end
      if (op == OP_ASIN) begin
         if (py > UNIT)  py = UNIT;
         if (py < -UNIT) py = -UNIT;
      end
      best     = 0;
      best_err = 0;
      for (int j = 0; j < FULL_ANCHORS; j++) begin
         anchor_of(j, ac, as_val);
         dy     = as_val - py;
         sq_err = dy * dy;
         if (op == OP_ATAN2) begin
            dx     = ac - px;
            sq_err += dx * dx;
         end
         if (j == 0 || sq_err < best_err) begin
            best_err = sq_err;
            best     = j;
         end
      end
      return OUT_W'(best);
   endfunction

   // ---------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------

   // Presents one item and holds it until the transfer. Valid is only lowered for an idle
   // burst, so back-to-back items keep it high with one assignment per clock edge.
   task automatic send_item(input logic op, input logic [IN_W-1:0] x, input logic [IN_W-1:0] y);
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_x_value <= x;
      req_y_value <= y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // Transfer happened at this edge.
      angle_expected = {angle_expected, nearest_anchor(op, $signed(x), $signed(y))};
      items_sent++;
   endtask

   // Idle the request side until every outstanding result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (angle_expected.size() != 0);
   endtask

   // Coordinate with a spread of magnitudes: full 16-bit range, around the unit circle,
   // near the origin, and exact corner values.
   function automatic logic [IN_W-1:0] random_coord();
      case ($urandom_range(0, 5))
         0, 1: return IN_W'($urandom);
         2, 3: return IN_W'(int'($urandom_range(0, 10000)) - 5000);
         4:    return IN_W'(int'($urandom_range(0, 128)) - 64);
         default: begin
            case ($urandom_range(0, 5))
               0: return 16'sh8000;
               1: return 16'sh7FFF;
               2: return 16'sh0000;
               3: return IN_W'(UNIT);
               4: return IN_W'(-UNIT);
               default: return 16'shFFFF;
            endcase
         end
      endcase
   endfunction

   function automatic logic [IN_W-1:0] saturate(input longint v);
      if (v > 32767)  return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return IN_W'(v);
   endfunction

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Corners, axes, the origin, clamping and index ties.
   task automatic test_directed_corners();
      send_item(OP_ATAN2, 16'sh0000, 16'sh0000);   // origin returns index 0 at once
      send_item(OP_ASIN,  16'sh0000, 16'sh0000);   // sine 0 at 0 and 128: lowest wins
      send_item(OP_ATAN2, 16'sh7FFF, 16'sh7FFF);
      send_item(OP_ATAN2, 16'sh8000, 16'sh8000);
      send_item(OP_ATAN2, 16'sh8000, 16'sh7FFF);
      send_item(OP_ATAN2, 16'sh7FFF, 16'sh8000);
      send_item(OP_ATAN2, 16'sh8000, 16'sh0000);   // exactly on the negative x axis
      send_item(OP_ATAN2, 16'sh1000, 16'sh0000);
      send_item(OP_ATAN2, 16'sh0000, 16'sh1000);
      send_item(OP_ATAN2, 16'shF000, 16'sh0000);
      send_item(OP_ATAN2, 16'sh0000, 16'shF000);
      send_item(OP_ATAN2, 16'sh0001, 16'sh0000);   // one LSB off the origin
      send_item(OP_ATAN2, 16'shFFFF, 16'shFFFF);
      send_item(OP_ASIN,  16'sh8000, 16'sh1000);   // x is ignored for asin
      send_item(OP_ASIN,  16'sh7FFF, 16'shF000);
      send_item(OP_ASIN,  16'sh0000, 16'sh1001);   // just beyond one, clamped
      send_item(OP_ASIN,  16'sh0000, 16'shEFFF);
      send_item(OP_ASIN,  16'sh0000, 16'sh7FFF);
      send_item(OP_ASIN,  16'sh0000, 16'sh8000);
      send_item(OP_ASIN,  16'shFFFF, IN_W'(anchor_sin[32]));   // tie between 32 and 96
      send_item(OP_ASIN,  16'sh0000, IN_W'(-anchor_sin[10]));  // tie in the lower half
      send_item(OP_ASIN,  16'sh0000, 16'shFFFF);
   endtask

   task automatic test_random_points(input int count);
      for (int n = 0; n < count; n++) begin
         send_item(logic'($urandom_range(0, 1)), random_coord(), random_coord());
      end
   endtask

   // Points along rays through the anchors at radii from 1/4 to ~8, with small jitter,
   // so that the winner is often decided by a few LSBs.
   task automatic test_unit_circle_points(input int count);
      longint c, s, k;
      for (int n = 0; n < count; n++) begin
         anchor_of(int'($urandom_range(0, FULL_ANCHORS - 1)), c, s);
         k = $urandom_range(1, 31);
         send_item(OP_ATAN2,
                   saturate((c * k) / 4 + int'($urandom_range(0, 6)) - 3),
                   saturate((s * k) / 4 + int'($urandom_range(0, 6)) - 3));
      end
   endtask

   // asin near each anchor sine, with an occasional argument beyond one.
   task automatic test_asin_sweep(input int count);
      longint c, s;
      for (int n = 0; n < count; n++) begin
         anchor_of(int'($urandom_range(0, FULL_ANCHORS - 1)), c, s);
         if ($urandom_range(0, 7) == 0) begin
            send_item(OP_ASIN, IN_W'($urandom), random_coord());
         end else begin
            send_item(OP_ASIN, IN_W'($urandom),
                      saturate(s + int'($urandom_range(0, 4)) - 2));
         end
      end
   endtask

   // Short bursts, each followed by a full drain of outstanding results.
   task automatic test_drain_pause(input int rounds);
      for (int r = 0; r < rounds; r++) begin
         test_random_points(10);
         wait_for_results();
      end
   endtask

   // Closing stretch with no idling on either side.
   task automatic test_steady_stream(input int count);
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      test_random_points(count / 2);
      test_unit_circle_points(count - count / 2);
   endtask

   // ---------------------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------------------

   // Receiver backpressure: random stall bursts, otherwise ready.
   always begin
      @(posedge clock);
      if (receiver_stalls && $urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      rsp_ready <= 1'b1;
   end

   // Every response transfer is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (angle_expected.size() == 0) begin
            $error("angle_index: unexpected transfer, got %0d", rsp_angle_index);
            error_count++;
         end else begin
            angle_want = angle_expected.pop_front();
            if (rsp_angle_index !== angle_want) begin
               $error("angle_index mismatch: expected %0d, actual %0d",
                      angle_want, rsp_angle_index);
               error_count++;
            end
            results_checked++;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, angle_expected.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------

   initial begin
      load_anchor_table();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // The block loads its table after reset; req_ready holds off the first transfer.
      test_directed_corners();
      test_random_points(700);
      test_drain_pause(3);
      test_unit_circle_points(500);
      test_asin_sweep(350);
      test_steady_stream(350);
      req_valid <= 1'b0;
      while (angle_expected.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Covered %0d requests (atan2 and asin, corners, clamping, ties, near-circle)",
               items_sent);
      $display("and %0d checked responses in %0d cycles under random idle and stalls.",
               results_checked, cycle_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
